// ----- rtl/core/ptw_pkg.sv -----
package ptw_pkg;

	localparam int INDEX_BITS  = 9;
	localparam int NUM_LEVELS  = 5;
	localparam int VADDR_W     = 57;
	localparam int PADDR_W     = 52;
	localparam int ENTRY_W     = 64;
	localparam int PAB_W       = 6;
	localparam int LIMIT_W     = 41;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 52;
	localparam int S_TDATA_W   = 128;
	localparam int M_TDATA_W   = 376;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIVE_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHYS_BITS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIM  = 2'd3;

	localparam logic [PAB_W-1:0]   PHYS_BITS_MAX   = 6'd52;
	localparam logic [LIMIT_W-1:0] FRAME_LIM_RESET = 41'h100_0000_0000;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_ENTRY = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] PAGE_NONE = 2'd0;
	localparam logic [1:0] PAGE_4K   = 2'd1;
	localparam logic [1:0] PAGE_2M   = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;

	// level whose entry is awaited
	typedef enum logic [5:0] {
		LVL_IDLE = 6'b000001,
		LVL_1    = 6'b000010,
		LVL_2    = 6'b000100,
		LVL_3    = 6'b001000,
		LVL_4    = 6'b010000,
		LVL_5    = 6'b100000
	} lvl_t;

	typedef struct packed {
		logic [PADDR_W-1:0] root_base;
		logic               five_level;
		logic [PAB_W-1:0]   phys_bits;
		logic [LIMIT_W-1:0] frame_limit;
	} cfg_t;

	// entries[4] top, [3] l4, [2] l3, [1] l2, [0] l1
	typedef struct packed {
		lvl_t                                  level;
		logic [VADDR_W-1:0]                    vaddr;
		logic [NUM_LEVELS-1:0][ENTRY_W-1:0]    entries;
	} walk_t;

	typedef struct packed {
		logic                                  kind;
		logic [PADDR_W-1:0]                    read_address;
		logic [1:0]                            page_kind;
		logic                                  status;
		logic [NUM_LEVELS-1:0][ENTRY_W-1:0]    entries;
	} res_t;

	localparam logic [NUM_LEVELS-1:0][ENTRY_W-1:0] ENTRIES_CLEAR =
		{{ENTRY_W{1'b1}}, {(NUM_LEVELS-1)*ENTRY_W{1'b0}}};

endpackage

// ----- rtl/core/ptw_step.sv -----
module ptw_step #(
	parameter int PAGE_BITS = 12
) (
	input  ptw_pkg::cfg_t                   cfg,
	input  ptw_pkg::walk_t                  cur,
	input  logic                            mode,
	input  logic [ptw_pkg::VADDR_W-1:0]     virt_addr,
	input  logic [ptw_pkg::ENTRY_W-1:0]     read_entry,
	output ptw_pkg::walk_t                  nxt,
	output ptw_pkg::res_t                   res,
	output logic                            res_valid
);

	logic [ptw_pkg::PAB_W-1:0]      phys_bits;
	logic [ptw_pkg::PADDR_W-1:0]    addr_mask;
	logic                           do_req;
	logic [ptw_pkg::PADDR_W-1:0]    req_base;
	ptw_pkg::lvl_t                  req_lvl;
	logic [ptw_pkg::VADDR_W-1:0]    vaddr_use;
	logic                           fin;
	logic [1:0]                     fin_page;
	logic                           fin_status;
	logic [ptw_pkg::INDEX_BITS-1:0] idx;
	logic [ptw_pkg::PADDR_W-1:0]    req_addr;
	logic [ptw_pkg::PADDR_W-1:0]    req_frame;
	logic                           frame_bad;
	ptw_pkg::walk_t                 upd;

	assign phys_bits = (cfg.phys_bits > ptw_pkg::PHYS_BITS_MAX) ? ptw_pkg::PHYS_BITS_MAX
		: cfg.phys_bits;

	always_comb begin
		for (int i = 0; i < ptw_pkg::PADDR_W; i++) begin
			addr_mask[i] = (i >= PAGE_BITS) && (ptw_pkg::PAB_W'(i) < phys_bits);
		end
	end

	// decode the item: entry capture, early finish, or next table read
	always_comb begin
		upd        = cur;
		do_req     = 1'b0;
		req_base   = '0;
		req_lvl    = ptw_pkg::LVL_IDLE;
		vaddr_use  = cur.vaddr;
		fin        = 1'b0;
		fin_page   = ptw_pkg::PAGE_NONE;
		fin_status = ptw_pkg::STATUS_OK;
		if (mode == ptw_pkg::MODE_START) begin
			if (cur.level == ptw_pkg::LVL_IDLE) begin
				upd.vaddr   = virt_addr;
				upd.entries = ptw_pkg::ENTRIES_CLEAR;
				vaddr_use   = virt_addr;
				do_req      = 1'b1;
				req_base    = cfg.root_base & addr_mask;
				req_lvl     = cfg.five_level ? ptw_pkg::LVL_5 : ptw_pkg::LVL_4;
			end
		end else if (cur.level != ptw_pkg::LVL_IDLE) begin
			unique case (cur.level)
				ptw_pkg::LVL_1: upd.entries[0] = read_entry;
				ptw_pkg::LVL_2: upd.entries[1] = read_entry;
				ptw_pkg::LVL_3: upd.entries[2] = read_entry;
				ptw_pkg::LVL_4: upd.entries[3] = read_entry;
				ptw_pkg::LVL_5: upd.entries[4] = read_entry;
				default: ;
			endcase
			if (cur.level == ptw_pkg::LVL_1) begin
				fin      = 1'b1;
				fin_page = read_entry[ptw_pkg::BIT_PRESENT] ? ptw_pkg::PAGE_4K
					: ptw_pkg::PAGE_NONE;
			end else if (!read_entry[ptw_pkg::BIT_PRESENT]) begin
				fin        = 1'b1;
				fin_status = ptw_pkg::STATUS_BAD;
			end else if (cur.level == ptw_pkg::LVL_2 && read_entry[ptw_pkg::BIT_LARGE]) begin
				fin      = 1'b1;
				fin_page = ptw_pkg::PAGE_2M;
			end else begin
				do_req   = 1'b1;
				req_base = read_entry[ptw_pkg::PADDR_W-1:0] & addr_mask;
				unique case (cur.level)
					ptw_pkg::LVL_5: req_lvl = ptw_pkg::LVL_4;
					ptw_pkg::LVL_4: req_lvl = ptw_pkg::LVL_3;
					ptw_pkg::LVL_3: req_lvl = ptw_pkg::LVL_2;
					default:        req_lvl = ptw_pkg::LVL_1;
				endcase
			end
		end
	end

	always_comb begin
		unique case (req_lvl)
			ptw_pkg::LVL_1: idx = ptw_pkg::INDEX_BITS'(vaddr_use >> PAGE_BITS);
			ptw_pkg::LVL_2: idx = ptw_pkg::INDEX_BITS'(vaddr_use >>
				(PAGE_BITS + ptw_pkg::INDEX_BITS));
			ptw_pkg::LVL_3: idx = ptw_pkg::INDEX_BITS'(vaddr_use >>
				(PAGE_BITS + 2 * ptw_pkg::INDEX_BITS));
			ptw_pkg::LVL_4: idx = ptw_pkg::INDEX_BITS'(vaddr_use >>
				(PAGE_BITS + 3 * ptw_pkg::INDEX_BITS));
			ptw_pkg::LVL_5: idx = ptw_pkg::INDEX_BITS'(vaddr_use >>
				(PAGE_BITS + 4 * ptw_pkg::INDEX_BITS));
			default:        idx = '0;
		endcase
	end

	assign req_addr  = req_base + ptw_pkg::PADDR_W'({idx, 3'b000});
	assign req_frame = req_addr >> PAGE_BITS;
	assign frame_bad = req_frame >= ptw_pkg::PADDR_W'(cfg.frame_limit);

	always_comb begin
		nxt       = upd;
		res       = '0;
		res_valid = 1'b0;
		if (do_req && !frame_bad) begin
			nxt.level        = req_lvl;
			res.kind         = ptw_pkg::KIND_READ;
			res.read_address = req_addr;
			res_valid        = 1'b1;
		end else if (fin || do_req) begin
			// table frame out of range ends the walk without a read
			nxt.level     = ptw_pkg::LVL_IDLE;
			res.kind      = ptw_pkg::KIND_DONE;
			res.page_kind = do_req ? ptw_pkg::PAGE_NONE : fin_page;
			res.status    = do_req ? ptw_pkg::STATUS_BAD : fin_status;
			res.entries   = upd.entries;
			res_valid     = 1'b1;
		end
	end

endmodule

// ----- rtl/core/page_table_walker_top.sv -----
// Page table walker, four or five levels.
// Input stream s_*: tuser = mode (0 start, 1 entry); tdata = virt_addr on start,
// read_entry on an entry transfer. Output stream m_*: tuser = kind (0 read request,
// 1 done); tdata carries the read address or the done result with all entries.
// A start asks for the top entry; each returned entry yields the next read or the
// done result. Starts during a walk and entries while idle are dropped silently.
// Throughput: one input transfer per cycle while s_tready is high. Each transfer
// is decoded in a single combinational step from the walk registers into the
// result register, so a result is shown on m_* the cycle after its input transfer.
// The result register decouples the sides: s_tready stays high while the result
// register is empty or being taken this cycle; when m_tready is low with a result
// held, s_tready drops and the result holds stable.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) are registered; write them
// only while no walk is in flight.
// Reset: walker idle, no result pending, registers at their defaults (root 0,
// four levels, 52 physical bits, frame limit 2^40).
module page_table_walker_top #(
	parameter int PAGE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [56:0] virt_addr, [120:57] read_entry, [127:121] zero
	input  logic [ptw_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] mode
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [51:0] read_address, [53:52] page_kind, [54] status, [118:55] top_entry,
	// [182:119] l4_entry, [246:183] l3_entry, [310:247] l2_entry,
	// [374:311] l1_entry, [375] zero
	output logic [ptw_pkg::M_TDATA_W-1:0]     m_tdata,
	// [0] kind
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	ptw_pkg::cfg_t  cfg_q;
	ptw_pkg::walk_t walk_q;
	ptw_pkg::walk_t walk_nxt;
	ptw_pkg::res_t  res_nxt;
	ptw_pkg::res_t  res_q;
	logic           res_nxt_valid;
	logic           out_valid_q;
	logic           in_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.root_base   <= '0;
			cfg_q.five_level  <= 1'b0;
			cfg_q.phys_bits   <= ptw_pkg::PHYS_BITS_MAX;
			cfg_q.frame_limit <= ptw_pkg::FRAME_LIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptw_pkg::REG_ROOT_BASE:  cfg_q.root_base   <= cfg_wdata;
				ptw_pkg::REG_FIVE_LEVEL: cfg_q.five_level  <= cfg_wdata[0];
				ptw_pkg::REG_PHYS_BITS:  cfg_q.phys_bits   <= cfg_wdata[ptw_pkg::PAB_W-1:0];
				ptw_pkg::REG_FRAME_LIM:  cfg_q.frame_limit <= cfg_wdata[ptw_pkg::LIMIT_W-1:0];
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	ptw_step #(
		.PAGE_BITS(PAGE_BITS)
	) u_step (
		.cfg        (cfg_q),
		.cur        (walk_q),
		.mode       (s_tuser),
		.virt_addr  (s_tdata[ptw_pkg::VADDR_W-1:0]),
		.read_entry (s_tdata[ptw_pkg::VADDR_W +: ptw_pkg::ENTRY_W]),
		.nxt        (walk_nxt),
		.res        (res_nxt),
		.res_valid  (res_nxt_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.level   <= ptw_pkg::LVL_IDLE;
			walk_q.vaddr   <= '0;
			walk_q.entries <= ptw_pkg::ENTRIES_CLEAR;
			out_valid_q    <= 1'b0;
		end else if (in_xfer) begin
			walk_q      <= walk_nxt;
			out_valid_q <= res_nxt_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res_nxt_valid) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {1'b0, res_q.entries[0], res_q.entries[1], res_q.entries[2],
		res_q.entries[3], res_q.entries[4], res_q.status, res_q.page_kind,
		res_q.read_address};

endmodule

// ----- rtl/core/ptw_checker.sv -----
module ptw_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [ptw_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ptw_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// a held result must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input side only waits on a full, stalled result register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow result register");

	a_done_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ptw_pkg::KIND_DONE |-> m_tdata[ptw_pkg::PADDR_W-1:0] == '0)
		else $error("done transfer carries a read address");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ptw_pkg::KIND_READ
		|-> m_tdata[ptw_pkg::M_TDATA_W-1:ptw_pkg::PADDR_W] == '0)
		else $error("read request carries walk results");

	a_page_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ptw_pkg::PADDR_W+1:ptw_pkg::PADDR_W] != 2'b11)
		else $error("undefined page kind");

endmodule

bind page_table_walker_top ptw_checker u_ptw_checker (.*);
